[hdl/fsl_pkg.sv]
package fsl_pkg;

  // Default sizes of the block.
  localparam int LINE_BUFFER_DEF = 1024;
  localparam int PATTERN_MAX_DEF = 16;

  // Widths fixed by the register and field definitions.
  localparam int CFG_DATA_W   = 64;
  localparam int CFG_INDEX_W  = 2;
  localparam int LINE_NUM_W   = 32;
  localparam int CHUNK_LEN_W  = 10;
  localparam int PAT_BYTES    = 16;
  localparam int PAT_LEN_W    = 5;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LOW    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_HIGH   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SHOW_NUMBERS   = 2'd3;

  localparam logic [7:0] NEWLINE_BYTE = 8'h0A;

  // Control shared by every cell of the window chain.
  typedef struct packed {
    logic shift;
    logic clear;
  } fsl_cell_ctrl_t;

endpackage

[hdl/fsl_if.sv]
// Input channel: one file byte per item.
interface fsl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       file_end;

  modport source (output valid, output in_byte, output file_end, input ready);
  modport sink   (input valid, input in_byte, input file_end, output ready);
endinterface

// Result channel: one verdict per finished chunk.
interface fsl_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] line_number;
  logic [9:0]  chunk_length;
  logic        matched;

  modport source (output valid, output line_number, output chunk_length,
                  output matched, input ready);
  modport sink   (input valid, input line_number, input chunk_length,
                  input matched, output ready);
endinterface

[hdl/fsl_cell.sv]
module fsl_cell
  import fsl_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  fsl_cell_ctrl_t ctrl,
  input  logic [7:0]     prev_byte,
  input  logic           prev_valid,
  input  logic [7:0]     pat_byte,
  output logic [7:0]     byte_q,
  output logic           valid_q,
  output logic           hit
);

  logic [7:0] byte_r;
  logic [7:0] byte_nxt;
  logic       valid_r;
  logic       valid_nxt;

  // Shift in the neighbor's byte; a chunk end empties the cell.
  always_comb begin
    byte_nxt  = byte_r;
    valid_nxt = valid_r;
    if (ctrl.clear) begin
      valid_nxt = 1'b0;
    end else if (ctrl.shift) begin
      byte_nxt  = prev_byte;
      valid_nxt = prev_valid;
    end
  end

  // The compare looks at the byte this cell holds after the shift.
  assign hit = prev_valid && (prev_byte == pat_byte);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
  end

  assign byte_q  = byte_r;
  assign valid_q = valid_r;

endmodule

[hdl/fixed_string_line_filter.sv]
// Channel   Direction  Payload
// in_chan   sink       in_byte[7:0], file_end
// out_chan  source     line_number[31:0], chunk_length[9:0], matched
// cfg_*     write      cfg_index[1:0], cfg_data[63:0]
//
// One byte is taken every cycle; the window of recent bytes is a row of
// PATTERN_MAX cells compared in parallel, so a verdict leaves in the cycle
// after the byte that ends its chunk. The result register lets a new byte
// enter in the same cycle the pending verdict is taken; while a verdict
// waits and out_chan.ready is low, in_chan.ready is low. rst_n is synchronous
// and clears the window, counters and the result register.
module fixed_string_line_filter
  import fsl_pkg::*;
#(
  parameter int LINE_BUFFER = LINE_BUFFER_DEF,
  parameter int PATTERN_MAX = PATTERN_MAX_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  fsl_in_if.sink                 in_chan,
  fsl_out_if.source              out_chan,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int CW = $clog2(LINE_BUFFER);
  localparam int LW = (CW > CHUNK_LEN_W) ? CW : CHUNK_LEN_W;
  localparam logic [CW-1:0] CHUNK_MAX = CW'(LINE_BUFFER - 1);
  localparam logic [PAT_LEN_W-1:0] LEN_LIMIT = PAT_LEN_W'(PATTERN_MAX);

  // Configuration registers.
  logic [CFG_DATA_W-1:0] pat_low_r;
  logic [CFG_DATA_W-1:0] pat_high_r;
  logic [PAT_LEN_W-1:0]  pat_len_r;
  logic                  show_num_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_low_r  <= '0;
      pat_high_r <= '0;
      pat_len_r  <= '0;
      show_num_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PATTERN_LOW:    pat_low_r  <= cfg_data;
        REG_PATTERN_HIGH:   pat_high_r <= cfg_data;
        REG_PATTERN_LENGTH: pat_len_r  <= cfg_data[PAT_LEN_W-1:0];
        REG_SHOW_NUMBERS:   show_num_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Pattern bytes and the length in use: the pattern stops at its first
  // zero byte and never runs past the window.
  logic [7:0]           pat_bytes [PAT_BYTES];
  logic [PAT_LEN_W-1:0] len_lim;
  logic [PAT_LEN_W-1:0] plen;

  always_comb begin
    for (int i = 0; i < PAT_BYTES; i++) begin
      pat_bytes[i] = (i < 8) ? pat_low_r[8*(i%8) +: 8] : pat_high_r[8*(i%8) +: 8];
    end
  end

  assign len_lim = (pat_len_r > LEN_LIMIT) ? LEN_LIMIT : pat_len_r;

  always_comb begin
    plen = len_lim;
    for (int i = PAT_BYTES - 1; i >= 0; i--) begin
      if ((PAT_LEN_W'(i) < len_lim) && (pat_bytes[i] == 8'h00)) begin
        plen = PAT_LEN_W'(i);
      end
    end
  end

  // Handshake and chunk control.
  logic                  accept;
  logic                  chunk_end;
  logic                  zero_seen_r;
  logic                  zero_seen_nxt;
  logic                  found_r;
  logic                  found_nxt;
  logic [CW-1:0]         count_r;
  logic [CW-1:0]         count_inc;
  logic [CW-1:0]         count_nxt;
  logic [LINE_NUM_W-1:0] line_r;
  logic [LINE_NUM_W-1:0] line_nxt;
  logic                  win_hit;
  fsl_cell_ctrl_t        cell_ctrl;

  logic                  out_valid_r;
  logic                  out_valid_nxt;
  logic [LINE_NUM_W-1:0] out_line_r;
  logic [CHUNK_LEN_W-1:0] out_len_r;
  logic                  out_match_r;
  logic [LW-1:0]         len_wide;

  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign accept        = in_chan.valid && in_chan.ready;
  assign count_inc     = count_r + CW'(1);
  assign chunk_end     = (in_chan.in_byte == NEWLINE_BYTE) ||
                         (count_inc >= CHUNK_MAX) || in_chan.file_end;

  assign cell_ctrl.clear = accept && chunk_end;
  assign cell_ctrl.shift = accept && !zero_seen_r && (in_chan.in_byte != 8'h00);

  // Window chain: cell k holds the k-th most recent byte of the chunk.
  logic [7:0]             cell_byte  [PATTERN_MAX];
  logic [PATTERN_MAX-1:0] cell_valid;
  logic [PATTERN_MAX-1:0] cell_hit;
  logic [PATTERN_MAX-1:0] cell_ok;

  for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
    logic [7:0]           prev_byte;
    logic                 prev_valid;
    logic [PAT_LEN_W-1:0] pat_idx;
    logic                 in_use;

    if (k == 0) begin : g_head
      assign prev_byte  = in_chan.in_byte;
      assign prev_valid = 1'b1;
    end else begin : g_link
      assign prev_byte  = cell_byte[k-1];
      assign prev_valid = cell_valid[k-1];
    end

    // Cell k lines up with pattern byte plen-1-k.
    assign in_use     = PAT_LEN_W'(k) < plen;
    assign pat_idx    = plen - PAT_LEN_W'(k) - PAT_LEN_W'(1);
    assign cell_ok[k] = !in_use || cell_hit[k];

    fsl_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (cell_ctrl),
      .prev_byte  (prev_byte),
      .prev_valid (prev_valid),
      .pat_byte   (pat_bytes[pat_idx[3:0]]),
      .byte_q     (cell_byte[k]),
      .valid_q    (cell_valid[k]),
      .hit        (cell_hit[k])
    );
  end

  assign win_hit = (plen != '0) && (&cell_ok);

  // Chunk state update.
  always_comb begin
    zero_seen_nxt = zero_seen_r;
    found_nxt     = found_r;
    count_nxt     = count_r;
    line_nxt      = line_r;
    if (accept) begin
      if (cell_ctrl.shift && win_hit) begin
        found_nxt = 1'b1;
      end
      if (!zero_seen_r && (in_chan.in_byte == 8'h00)) begin
        zero_seen_nxt = 1'b1;
      end
      count_nxt = count_inc;
      if (chunk_end) begin
        zero_seen_nxt = 1'b0;
        count_nxt     = '0;
        if (in_chan.file_end) begin
          line_nxt = LINE_NUM_W'(1);
        end else if (line_r != '1) begin
          line_nxt = line_r + LINE_NUM_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_seen_r <= 1'b0;
      found_r     <= 1'b0;
      count_r     <= '0;
      line_r      <= LINE_NUM_W'(1);
    end else begin
      zero_seen_r <= zero_seen_nxt;
      found_r     <= cell_ctrl.clear ? 1'b0 : found_nxt;
      count_r     <= count_nxt;
      line_r      <= line_nxt;
    end
  end

  // Result register.
  assign len_wide = LW'(count_inc);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cell_ctrl.clear) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cell_ctrl.clear) begin
      out_line_r  <= show_num_r ? line_r : '0;
      out_len_r   <= len_wide[CHUNK_LEN_W-1:0];
      out_match_r <= found_nxt || (plen == '0);
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.line_number  = out_line_r;
  assign out_chan.chunk_length = out_len_r;
  assign out_chan.matched      = out_match_r;

endmodule

[sim/tb_fixed_string_line_filter.sv]
`timescale 1ns / 100ps

module tb_fixed_string_line_filter;
  import fsl_pkg::*;

  // One file byte as it waits to be sent.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } file_byte_t;

  // One verdict for a finished chunk.
  typedef struct packed {
    logic [LINE_NUM_W-1:0]  line_number;
    logic [CHUNK_LEN_W-1:0] chunk_length;
    logic                   matched;
  } verdict_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  fsl_in_if  in_chan ();
  fsl_out_if out_chan ();

  fixed_string_line_filter dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #1 clk = ~clk;

  // Bytes still to be sent and verdicts still to arrive.
  file_byte_t pending_bytes[$];
  verdict_t expected_verdicts[$];

  int send_idle_pct = 31;
  int recv_idle_pct = 65;
  logic byte_taken = 1'b0;

  int errors = 0;
  int bytes_pushed = 0;
  int bytes_seen = 0;
  int chunks_seen = 0;
  int matches_seen = 0;
  int settings_used = 0;

  // Register copies.
  logic [63:0] pat_low = '0;
  logic [63:0] pat_high = '0;
  logic [PAT_LEN_W-1:0] pat_len = '0;
  logic show_num = 1'b0;

  // Chunk scanner state.
  logic [7:0] window [PAT_BYTES] = '{default: '0};
  int chunk_bytes = 0;
  int usable = 0;
  logic found = 1'b0;
  logic zero_hit = 1'b0;
  logic [LINE_NUM_W-1:0] line_count = 1;

  function automatic logic [7:0] pattern_byte(int i);
    logic [127:0] bits;
    bits = {pat_high, pat_low};
    return bits[i*8 +: 8];
  endfunction

  // The pattern ends at its first zero byte and never exceeds the window.
  function automatic int pattern_len_in_use();
    int lim;
    lim = (pat_len > PAT_BYTES) ? PAT_BYTES : int'(pat_len);
    for (int i = 0; i < lim; i++) begin
      if (pattern_byte(i) == 8'h00) return i;
    end
    return lim;
  endfunction

  function automatic void clear_chunk();
    for (int i = 0; i < PAT_BYTES; i++) window[i] = '0;
    chunk_bytes = 0;
    usable = 0;
    found = 1'b0;
    zero_hit = 1'b0;
  endfunction

  // Feeds one byte to the scanner; returns 1 when it closes a chunk.
  function automatic logic scan_byte(input logic [7:0] b, input logic last,
                                     output verdict_t v);
    int plen;
    logic hit;
    plen = pattern_len_in_use();
    v = '0;
    chunk_bytes++;
    if (!zero_hit) begin
      if (b == 8'h00) begin
        zero_hit = 1'b1;
      end else begin
        for (int i = PAT_BYTES - 1; i > 0; i--) window[i] = window[i-1];
        window[0] = b;
        if (usable < PAT_BYTES) usable++;
        if (plen > 0 && usable >= plen) begin
          hit = 1'b1;
          for (int i = 0; i < plen; i++) begin
            if (window[plen-1-i] != pattern_byte(i)) hit = 1'b0;
          end
          if (hit) found = 1'b1;
        end
      end
    end
    if (b == NEWLINE_BYTE || chunk_bytes >= LINE_BUFFER_DEF - 1 || last) begin
      v.line_number = show_num ? line_count : '0;
      v.chunk_length = chunk_bytes[CHUNK_LEN_W-1:0];
      v.matched = found || plen == 0;
      if (last) begin
        line_count = 1;
      end else if (line_count != '1) begin
        line_count++;
      end
      clear_chunk();
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Byte driver: holds an item until it is taken, then offers the next one.
  always @(negedge clk) begin
    file_byte_t nb;
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
      in_chan.in_byte <= '0;
      in_chan.file_end <= 1'b0;
    end else if (!in_chan.valid || byte_taken) begin
      if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        nb = pending_bytes.pop_front();
        in_chan.valid <= 1'b1;
        in_chan.in_byte <= nb.data;
        in_chan.file_end <= nb.last;
      end else begin
        in_chan.valid <= 1'b0;
      end
    end
  end

  // Verdict receiver stalls at random.
  always @(negedge clk) begin
    out_chan.ready <= rst_n && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Monitor: predicts on every accepted byte and checks every verdict.
  always @(posedge clk) begin
    verdict_t want;
    verdict_t got;
    if (!rst_n) begin
      byte_taken <= 1'b0;
    end else begin
      byte_taken <= in_chan.valid && in_chan.ready;
      if (in_chan.valid && in_chan.ready) begin
        bytes_seen++;
        if (scan_byte(in_chan.in_byte, in_chan.file_end, want))
          expected_verdicts.push_back(want);
      end
      if (out_chan.valid && out_chan.ready) begin
        got.line_number = out_chan.line_number;
        got.chunk_length = out_chan.chunk_length;
        got.matched = out_chan.matched;
        chunks_seen++;
        if (got.matched) matches_seen++;
        if (expected_verdicts.size() == 0) begin
          errors++;
          $display("%0t: unexpected verdict, expected none, got line %0d length %0d matched %0b",
                   $time, got.line_number, got.chunk_length, got.matched);
        end else begin
          want = expected_verdicts.pop_front();
          if (got.line_number !== want.line_number) begin
            errors++;
            $display("%0t: line_number expected %0d, got %0d",
                     $time, want.line_number, got.line_number);
          end
          if (got.chunk_length !== want.chunk_length) begin
            errors++;
            $display("%0t: chunk_length expected %0d, got %0d",
                     $time, want.chunk_length, got.chunk_length);
          end
          if (got.matched !== want.matched) begin
            errors++;
            $display("%0t: matched expected %0b, got %0b",
                     $time, want.matched, got.matched);
          end
        end
      end
    end
  end

  task automatic push_byte(logic [7:0] b, logic last = 1'b0);
    pending_bytes.push_back('{data: b, last: last});
    bytes_pushed++;
  endtask

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  // Writes one register at a quiet moment and keeps the copy in step.
  task automatic set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      REG_PATTERN_LOW:    pat_low = data;
      REG_PATTERN_HIGH:   pat_high = data;
      REG_PATTERN_LENGTH: pat_len = data[PAT_LEN_W-1:0];
      REG_SHOW_NUMBERS:   show_num = data[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Waits until every byte is taken and every verdict has arrived,
  // then lets a byte that closes no chunk settle.
  task automatic wait_quiet();
    while (pending_bytes.size() != 0 || in_chan.valid || expected_verdicts.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic logic [127:0] rand_pattern(logic narrow);
    logic [127:0] bits;
    for (int i = 0; i < PAT_BYTES; i++)
      bits[i*8 +: 8] = narrow ? 8'($urandom_range(8'h61, 8'h64)) : 8'($urandom_range(1, 255));
    return bits;
  endfunction

  // Each phase uses its own pattern shape and numbering choice.
  task automatic setup_phase(int k);
    logic [127:0] bits;
    logic [CFG_DATA_W-1:0] plen;
    case (k)
      0: begin
        bits = rand_pattern(1'b0);
        bits[127:64] = '1;
        plen = 64'd16;
      end
      1: begin
        bits = rand_pattern(1'b1);
        plen = 64'd31;
      end
      2: begin
        bits = {$urandom, $urandom, 64'h0};
        plen = '0;
      end
      3: begin
        bits = rand_pattern(1'b1);
        plen = 64'($urandom_range(1, 15));
      end
      default: begin
        bits = rand_pattern(1'b1);
        bits[$urandom_range(0, 15)*8 +: 8] = 8'h00;
        plen = 64'd16;
      end
    endcase
    set_reg(REG_PATTERN_LOW, bits[63:0]);
    set_reg(REG_PATTERN_HIGH, bits[127:64]);
    set_reg(REG_PATTERN_LENGTH, plen);
    set_reg(REG_SHOW_NUMBERS, (k == 0 || k >= 3) ? 64'd1 : 64'd0);
    settings_used++;
  endtask

  // One line of random text; about half of them carry the whole pattern.
  task automatic add_line();
    int len;
    int kind;
    int at;
    int plen;
    int r;
    logic [7:0] b;
    plen = pattern_len_in_use();
    kind = $urandom_range(0, 9);
    len = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 120) : $urandom_range(0, 24);
    at = (kind < 5 && plen > 0) ? $urandom_range(0, len) : -1;
    for (int p = 0; p <= len; p++) begin
      if (p == at) begin
        for (int q = 0; q < plen; q++) push_byte(pattern_byte(q));
      end
      if (p == len) break;
      r = $urandom_range(0, 19);
      if (kind == 9) b = 8'($urandom_range(0, 255));
      else if (r < 8) b = pattern_byte($urandom_range(0, 15));
      else if (r < 18) b = 8'($urandom_range(1, 255));
      else b = 8'h00;
      push_byte(b);
    end
    if ($urandom_range(0, 7) == 0)
      push_byte(($urandom_range(0, 1) == 0) ? NEWLINE_BYTE : 8'($urandom_range(0, 255)), 1'b1);
    else
      push_byte(NEWLINE_BYTE);
  endtask

  // Stimulus and end of run.
  initial begin
    int start;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_PATTERN_LOW;
    cfg_data = '0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // Values after reset: empty pattern, no numbering, extreme bytes.
    settings_used++;
    push_text("x");
    push_byte(NEWLINE_BYTE);
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(NEWLINE_BYTE);
    wait_quiet();

    // Pattern "abc": a plain hit, then one hidden behind a zero byte.
    set_reg(REG_PATTERN_LOW, 64'h0000_0000_0063_6261);
    set_reg(REG_PATTERN_LENGTH, 64'd3);
    set_reg(REG_SHOW_NUMBERS, 64'd1);
    settings_used++;
    push_text("zabc");
    push_byte(NEWLINE_BYTE);
    push_text("a");
    push_byte(8'h00);
    push_text("abc");
    push_byte(NEWLINE_BYTE);
    push_text("ab");
    wait_quiet();

    // Pattern changes while a chunk is open; the file ends on the next byte.
    set_reg(REG_PATTERN_LOW, 64'h0000_0000_0000_7862);
    set_reg(REG_PATTERN_LENGTH, 64'd2);
    settings_used++;
    push_byte("x", 1'b1);
    wait_quiet();

    // A zero byte inside the pattern shortens it to "ab".
    set_reg(REG_PATTERN_LOW, 64'h0000_0000_6300_6261);
    set_reg(REG_PATTERN_LENGTH, 64'd5);
    settings_used++;
    push_text("ab");
    push_byte(NEWLINE_BYTE);
    push_byte(NEWLINE_BYTE, 1'b1);
    wait_quiet();

    // Random phases under changing idling and register settings.
    for (int k = 0; k < 5; k++) begin
      if (k < 2) begin
        send_idle_pct = 31;
        recv_idle_pct = 65;
      end else if (k < 4) begin
        send_idle_pct = 65;
        recv_idle_pct = 31;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      setup_phase(k);
      start = bytes_pushed;
      if (k == 1) begin
        // A run without newlines fills the line buffer.
        for (int i = 0; i < 1030; i++) begin
          if ($urandom_range(0, 3) == 0) push_byte(8'($urandom_range(11, 255)));
          else push_byte(pattern_byte($urandom_range(0, 15)));
        end
      end
      while (bytes_pushed - start < 250) add_line();
      wait_quiet();
    end

    repeat (10) @(negedge clk);
    $display("Sent %0d bytes under %0d register settings; %0d chunk verdicts checked, %0d matched.",
             bytes_seen, settings_used, chunks_seen, matches_seen);
    if (errors == 0) begin
      $display("tb_fixed_string_line_filter: PASS");
    end else begin
      $display("tb_fixed_string_line_filter: FAIL");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #1000000;
    $display("tb_fixed_string_line_filter: FAIL");
    $finish;
  end

endmodule
